[hdl/nsfc_pkg.sv]
// ----------------------------------------------------------------------------
// nsfc_pkg
// Shared types and constants for the NMEA sentence framer and checksum checker.
// ----------------------------------------------------------------------------
package nsfc_pkg;

  localparam int unsigned LINE_CAPACITY = 256;
  localparam int unsigned CNT_W         = $clog2(LINE_CAPACITY);
  localparam int unsigned SHORT_LIMIT   = 6;

  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] PRINT_LO    = 8'h20;
  localparam logic [7:0] PRINT_HI    = 8'h7F;

  typedef enum logic [2:0] {
    KIND_START    = 3'd0,
    KIND_BODY     = 3'd1,
    KIND_GOOD     = 3'd2,
    KIND_BAD      = 3'd3,
    KIND_SHORT    = 3'd4,
    KIND_OVERFLOW = 3'd5
  } kind_e;

  // Classified byte handed from the front end to the sentence engine.
  typedef struct packed {
    logic [7:0] byte_val;
    logic       is_dollar;
    logic       is_eol;
    logic       is_print;
    logic       is_star;
    logic [4:0] hex;       // bit 4 set when the byte is a hex digit
  } item_t;

  // Reported length saturates at 255 for larger buffers.
  function automatic logic [7:0] sat_len(input logic [CNT_W-1:0] cnt);
    logic [31:0] wide;
    wide = 32'(cnt);
    return (wide > 32'd255) ? 8'hFF : wide[7:0];
  endfunction

endpackage

[hdl/nsfc_front.sv]
// ----------------------------------------------------------------------------
// nsfc_front
// Accepts received bytes and classifies them for the sentence engine.
// ----------------------------------------------------------------------------
module nsfc_front (
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      rx_byte_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output nsfc_pkg::item_t q_item_o
);

  function automatic logic [4:0] hex_code(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
      return {1'b1, v[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
      return {1'b1, v[3:0]};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
      return {1'b1, v[3:0]};
    end
    return 5'd0;
  endfunction

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_item_o.byte_val  = rx_byte_i;
    q_item_o.is_dollar = (rx_byte_i == nsfc_pkg::CHAR_DOLLAR);
    q_item_o.is_eol    = (rx_byte_i == nsfc_pkg::CHAR_CR) || (rx_byte_i == nsfc_pkg::CHAR_LF);
    q_item_o.is_print  = (rx_byte_i >= nsfc_pkg::PRINT_LO) && (rx_byte_i < nsfc_pkg::PRINT_HI);
    q_item_o.is_star   = (rx_byte_i == nsfc_pkg::CHAR_STAR);
    q_item_o.hex       = hex_code(rx_byte_i);
  end

endmodule

[hdl/nsfc_fifo.sv]
// ----------------------------------------------------------------------------
// nsfc_fifo
// Short queue of classified bytes between front end and sentence engine.
// ----------------------------------------------------------------------------
module nsfc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  nsfc_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output nsfc_pkg::item_t item_o
);

  nsfc_pkg::item_t mem_q [nsfc_pkg::QUEUE_DEPTH];
  logic [nsfc_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [nsfc_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [nsfc_pkg::QPTR_W:0]   count_q, count_d;
  logic do_push, do_pop;

  assign full_o  = (count_q == (nsfc_pkg::QPTR_W+1)'(nsfc_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[hdl/nsfc_back.sv]
// ----------------------------------------------------------------------------
// nsfc_back
// Sentence engine: tracks framing, running XOR and checksum digits, and
// holds the result register.
// ----------------------------------------------------------------------------
module nsfc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  nsfc_pkg::item_t q_item_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [2:0]      kind_o,
  output logic [7:0]      char_out_o,
  output logic [7:0]      line_length_o
);

  logic                       in_sent_q, in_sent_d;
  logic [nsfc_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]                 xor_q, xor_d;
  logic [7:0]                 star_xor_q, star_xor_d;
  logic                       star_q, star_d;
  logic [1:0]                 after_q, after_d;
  logic [4:0]                 hex1_q, hex1_d;
  logic [4:0]                 hex2_q, hex2_d;

  logic                       ovalid_q, ovalid_d;
  nsfc_pkg::kind_e            kind_q, kind_d;
  logic [7:0]                 char_q, char_d;
  logic [7:0]                 len_q, len_d;

  logic       sum_good;
  logic [7:0] want;
  logic       emit;

  assign q_pop_o = q_valid_i && (!ovalid_q || out_ready_i);

  always_comb begin
    want = hex2_q[4] ? {hex1_q[3:0], hex2_q[3:0]} : {4'h0, hex1_q[3:0]};
    sum_good = star_q && (after_q == 2'd2) && hex1_q[4] && (star_xor_q == want);
  end

  always_comb begin
    in_sent_d  = in_sent_q;
    cnt_d      = cnt_q;
    xor_d      = xor_q;
    star_xor_d = star_xor_q;
    star_d     = star_q;
    after_d    = after_q;
    hex1_d     = hex1_q;
    hex2_d     = hex2_q;
    emit       = 1'b0;
    kind_d     = kind_q;
    char_d     = 8'h00;

    if (q_pop_o) begin
      if (q_item_i.is_dollar) begin
        in_sent_d  = 1'b1;
        cnt_d      = nsfc_pkg::CNT_W'(1);
        xor_d      = '0;
        star_xor_d = '0;
        star_d     = 1'b0;
        after_d    = '0;
        hex1_d     = '0;
        hex2_d     = '0;
        emit       = 1'b1;
        kind_d     = nsfc_pkg::KIND_START;
        char_d     = q_item_i.byte_val;
      end else if (in_sent_q) begin
        if (q_item_i.is_eol) begin
          in_sent_d = 1'b0;
          emit      = 1'b1;
          if (cnt_q <= nsfc_pkg::CNT_W'(nsfc_pkg::SHORT_LIMIT)) begin
            kind_d = nsfc_pkg::KIND_SHORT;
          end else begin
            kind_d = sum_good ? nsfc_pkg::KIND_GOOD : nsfc_pkg::KIND_BAD;
          end
        end else if (cnt_q >= nsfc_pkg::CNT_W'(nsfc_pkg::LINE_CAPACITY - 1)) begin
          // buffer full: abandon the sentence
          in_sent_d = 1'b0;
          emit      = 1'b1;
          kind_d    = nsfc_pkg::KIND_OVERFLOW;
        end else if (q_item_i.is_print) begin
          if (q_item_i.is_star) begin
            star_xor_d = xor_q;
            star_d     = 1'b1;
            after_d    = '0;
            hex1_d     = '0;
            hex2_d     = '0;
          end else if (star_q) begin
            if (after_q == 2'd0) begin
              hex1_d = q_item_i.hex;
            end else if (after_q == 2'd1) begin
              hex2_d = q_item_i.hex;
            end
            if (after_q != 2'd2) begin
              after_d = after_q + 2'd1;
            end
          end
          xor_d  = xor_q ^ q_item_i.byte_val;
          cnt_d  = cnt_q + 1'b1;
          emit   = 1'b1;
          kind_d = nsfc_pkg::KIND_BODY;
          char_d = q_item_i.byte_val;
        end
      end
    end

    len_d = nsfc_pkg::sat_len(cnt_d);
    if (emit) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sent_q  <= 1'b0;
      cnt_q      <= '0;
      xor_q      <= '0;
      star_xor_q <= '0;
      star_q     <= 1'b0;
      after_q    <= '0;
      hex1_q     <= '0;
      hex2_q     <= '0;
      ovalid_q   <= 1'b0;
    end else begin
      in_sent_q  <= in_sent_d;
      cnt_q      <= cnt_d;
      xor_q      <= xor_d;
      star_xor_q <= star_xor_d;
      star_q     <= star_d;
      after_q    <= after_d;
      hex1_q     <= hex1_d;
      hex2_q     <= hex2_d;
      ovalid_q   <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= kind_d;
      char_q <= char_d;
      len_q  <= len_d;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign kind_o        = kind_q;
  assign char_out_o    = char_q;
  assign line_length_o = len_q;

endmodule

[hdl/nmea_sentence_framer_checker.sv]
// Path: an accepted byte is written into the byte queue; the sentence engine then
//   pops it and registers any result it yields; output stalls can hold it queued.
// Throughput: one byte per cycle while out_ready_i is high;
//   the 4-entry byte queue absorbs output stalls.
// Reset: rst_ni asynchronously clears framing state, the queue and output valid.
// ----------------------------------------------------------------------------
// nmea_sentence_framer_checker
// Frames NMEA sentences from a byte stream and verifies their checksum.
// ----------------------------------------------------------------------------
module nmea_sentence_framer_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] kind_o,
  output logic [7:0] char_out_o,
  output logic [7:0] line_length_o
);

  nsfc_pkg::item_t push_item, pop_item;
  logic            push, full, pop, q_valid;

  nsfc_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_item_o   (push_item)
  );

  nsfc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  nsfc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (pop_item),
    .q_pop_o       (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .char_out_o    (char_out_o),
    .line_length_o (line_length_o)
  );

endmodule

[hdl/nsfc_checker.sv]
// ----------------------------------------------------------------------------
// nsfc_checker
// Port-level checks on the sentence framer's result stream.
// ----------------------------------------------------------------------------
module nsfc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] rx_byte_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] kind_o,
  input logic [7:0] char_out_o,
  input logic [7:0] line_length_o
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o)
      && $stable(char_out_o) && $stable(line_length_o))
    else $error("result dropped or changed while stalled");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> kind_o <= nsfc_pkg::KIND_OVERFLOW)
    else $error("illegal result kind");

  // only start and body results carry a character
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != nsfc_pkg::KIND_START && kind_o != nsfc_pkg::KIND_BODY
      |-> char_out_o == 8'h00)
    else $error("end or abort result carries a character");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == nsfc_pkg::KIND_START
      |-> char_out_o == nsfc_pkg::CHAR_DOLLAR && line_length_o == 8'd1)
    else $error("start result is not a lone dollar sign");

  // a stalled request keeps its byte
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(rx_byte_i))
    else $error("input request dropped or changed while stalled");

endmodule

bind nmea_sentence_framer_checker nsfc_checker u_nsfc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .rx_byte_i     (rx_byte_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .kind_o        (kind_o),
  .char_out_o    (char_out_o),
  .line_length_o (line_length_o)
);
